### rtl/core/thr_pkg.sv
// Shared types and constants of the thick line rasterizer.
`timescale 1ns / 1ps
package thr_pkg;

  localparam int MAX_BAND    = 32;
  localparam int MAX_DIM     = 4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = 33;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PIXEL_BYTES  = 3'd2;
  localparam logic [2:0] REG_BAND_WIDTH   = 3'd3;
  localparam logic [2:0] REG_COLOR_RED    = 3'd4;
  localparam logic [2:0] REG_COLOR_GREEN  = 3'd5;
  localparam logic [2:0] REG_COLOR_BLUE   = 3'd6;

  localparam logic [2:0] RGB_PIXEL_BYTES = 3'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [25:0] byte_addr;
    logic [1:0]  byte_count;
    logic [23:0] pixel_data;
    logic        write_enable;
    logic        last_of_step;
    logic        line_done;
  } out_item_t;

  // Configuration as seen by the datapath, with width, height and band saturated
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [2:0]  pixel_bytes;
    logic [5:0]  band;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cfg_t;

  // One step job handed from front to back
  typedef struct packed {
    logic               draw;
    logic               done;
    logic               steep;
    logic signed [15:0] pos;
    logic signed [33:0] num;
    logic signed [16:0] den;
    logic signed [15:0] s_min;
  } step_t;

endpackage

### rtl/core/thr_front.sv
// Front end: takes commands, keeps line state, builds one step job per step command.
`timescale 1ns / 1ps
module thr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  thr_pkg::in_item_t item,
  input  thr_pkg::cfg_t   cfg,
  output logic            job_push,
  output thr_pkg::step_t  job
);
  import thr_pkg::*;

  logic signed [15:0] origin_x, origin_y, target_x, target_y;
  logic signed [15:0] major_position;
  logic               steep_flag, step_negative, line_active;

  // load path
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic               steep_new;
  logic signed [15:0] s_new, e_new;

  // step path
  logic signed [15:0] s_maj, s_min, e_maj, e_min;
  logic signed [15:0] pos_next;
  logic signed [16:0] rel, d_min, d_maj;
  logic [12:0]        major_lim;
  logic               in_range, active_next;

  always_comb begin
    dx        = 17'(item.end_x) - 17'(item.start_x);
    dy        = 17'(item.end_y) - 17'(item.start_y);
    adx       = dx[16] ? 17'(-dx) : 17'(dx);
    ady       = dy[16] ? 17'(-dy) : 17'(dy);
    steep_new = ady > adx;
    s_new     = steep_new ? item.start_y : item.start_x;
    e_new     = steep_new ? item.end_y : item.end_x;
  end

  always_comb begin
    s_maj     = steep_flag ? origin_y : origin_x;
    s_min     = steep_flag ? origin_x : origin_y;
    e_maj     = steep_flag ? target_y : target_x;
    e_min     = steep_flag ? target_x : target_y;
    major_lim = steep_flag ? cfg.height : cfg.width;
    pos_next  = step_negative ? major_position - 16'sd1 : major_position + 16'sd1;
    active_next = pos_next != e_maj;
    rel       = 17'(major_position) - 17'(s_maj);
    d_min     = 17'(e_min) - 17'(s_min);
    d_maj     = 17'(e_maj) - 17'(s_maj);
    in_range  = !major_position[15] && (major_position[14:0] < 15'(major_lim));
  end

  assign job_push = accept && (item.cmd == CMD_STEP);

  always_comb begin
    job.draw  = line_active && in_range;
    job.done  = !line_active || !active_next;
    job.steep = steep_flag;
    job.pos   = major_position;
    job.num   = 34'(rel) * 34'(d_min);
    job.den   = d_maj;
    job.s_min = s_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      target_x       <= '0;
      target_y       <= '0;
      major_position <= '0;
      steep_flag     <= 1'b0;
      step_negative  <= 1'b0;
      line_active    <= 1'b0;
    end else if (accept) begin
      if (item.cmd == CMD_LOAD) begin
        origin_x       <= item.start_x;
        origin_y       <= item.start_y;
        target_x       <= item.end_x;
        target_y       <= item.end_y;
        steep_flag     <= steep_new;
        step_negative  <= e_new < s_new;
        major_position <= s_new;
        line_active    <= s_new != e_new;
      end else if (line_active) begin
        major_position <= pos_next;
        line_active    <= active_next;
      end
    end
  end

endmodule

### rtl/core/thr_queue.sv
// Short job queue between front and back.
`timescale 1ns / 1ps
module thr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  thr_pkg::step_t wdata,
  input  logic           pop,
  output thr_pkg::step_t rdata,
  output logic           full,
  output logic           empty
);
  import thr_pkg::*;

  step_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/thr_back.sv
// Back end: divides for the minor coordinate, clips the band, emits pixel writes.
`timescale 1ns / 1ps
module thr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  thr_pkg::cfg_t        cfg,
  input  logic                 job_empty,
  input  thr_pkg::step_t       job_in,
  output logic                 job_pop,
  output logic                 empty,
  input  logic                 pop,
  output thr_pkg::out_item_t   result
);
  import thr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CLIP  = 3'd2;
  localparam logic [2:0] ST_ADDR1 = 3'd3;
  localparam logic [2:0] ST_ADDR2 = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_PLACE = 3'd6;

  logic [2:0]  state;
  step_t       job;

  // divider
  logic [32:0] quo;
  logic [16:0] rem, den_mag;
  logic        q_neg;
  logic [5:0]  div_cnt;
  logic [17:0] trial;
  logic        trial_ge;
  logic [33:0] num_abs;
  logic [16:0] den_abs;

  // clip
  logic signed [19:0] q20, minor, first, stop, lo_s, hi_s, lim_s;
  logic [12:0] minor_lim;
  logic [12:0] lo;
  logic [5:0]  remain;

  // address
  logic [12:0] row0, col0;
  logic [25:0] rw, addr, inc;

  // output
  logic        out_valid;
  logic        slot_free;
  logic        emit_beat;
  logic [1:0]  bytes;
  logic [23:0] color;

  assign slot_free = !out_valid || pop;
  assign emit_beat = slot_free && ((state == ST_EMIT) || (state == ST_PLACE));
  assign empty     = !out_valid;
  assign job_pop   = (state == ST_IDLE) && !job_empty;

  always_comb begin
    num_abs  = job_in.num[33] ? 34'(-job_in.num) : 34'(job_in.num);
    den_abs  = job_in.den[16] ? 17'(-job_in.den) : 17'(job_in.den);
    trial    = {rem, quo[32]};
    trial_ge = trial >= 18'(den_mag);
  end

  always_comb begin
    q20       = q_neg ? -$signed(quo[19:0]) : $signed(quo[19:0]);
    minor     = 20'(job.s_min) + q20;
    first     = minor - 20'(cfg.band >> 1);
    stop      = first + 20'(cfg.band);
    minor_lim = job.steep ? cfg.width : cfg.height;
    lim_s     = 20'(minor_lim);
    lo_s      = first[19] ? 20'sd0 : first;
    hi_s      = (stop > lim_s) ? lim_s : stop;
  end

  always_comb begin
    if (cfg.pixel_bytes == RGB_PIXEL_BYTES) begin
      bytes = 2'd3;
      color = {cfg.red, cfg.green, cfg.blue};
    end else begin
      bytes = 2'd1;
      color = {16'd0, cfg.red};
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job     <= job_in;
        quo     <= num_abs[32:0];
        den_mag <= den_abs;
        q_neg   <= job_in.num[33] ^ job_in.den[16];
        rem     <= '0;
        div_cnt <= 6'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        rem     <= trial_ge ? 17'(trial - 18'(den_mag)) : trial[16:0];
        quo     <= {quo[31:0], trial_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      ST_CLIP: begin
        lo     <= lo_s[12:0];
        remain <= 6'(hi_s - lo_s);
      end
      ST_ADDR1: begin
        rw <= 26'(row0) * 26'(cfg.width) + 26'(col0);
      end
      ST_ADDR2: begin
        addr <= 26'(rw * cfg.pixel_bytes);
        inc  <= job.steep ? 26'(cfg.pixel_bytes) : 26'(cfg.width) * 26'(cfg.pixel_bytes);
      end
      ST_EMIT: begin
        if (slot_free) begin
          addr   <= addr + inc;
          remain <= remain - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row0 = job.steep ? job.pos[12:0] : lo;
    col0 = job.steep ? lo : job.pos[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_beat) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= job_in.draw ? ST_DIV : ST_PLACE;
          end
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          // band fully clipped, or zero width
          state <= (hi_s > lo_s) ? ST_ADDR1 : ST_PLACE;
        end
        ST_ADDR1: state <= ST_ADDR2;
        ST_ADDR2: state <= ST_EMIT;
        ST_EMIT: begin
          if (slot_free) begin
            result.byte_addr    <= addr;
            result.byte_count   <= bytes;
            result.pixel_data   <= color;
            result.write_enable <= 1'b1;
            result.last_of_step <= remain == 6'd1;
            result.line_done    <= job.done;
            if (remain == 6'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_PLACE: begin
          if (slot_free) begin
            result.byte_addr    <= '0;
            result.byte_count   <= '0;
            result.pixel_data   <= '0;
            result.write_enable <= 1'b0;
            result.last_of_step <= 1'b1;
            result.line_done    <= job.done;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/thick_line_rasterizer.sv
// Top level of the thick line rasterizer: configuration registers, front, queue, back.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------
//   input     push / full          item   (in_item_t)
//   result    pop / empty          result (out_item_t)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load only updates line state in the front. A step that writes n pixels goes through
// the back in order: job taken, bit-serial divider, clip and two address stages, then one
// beat per cycle while the output register is free. A step whose band is clipped away, or
// that is off the image on the major axis or has no line, gives one write_enable-low beat.
// The two-entry job queue lets the front keep taking commands while the back works. Reset
// is synchronous; result beats stall in the output register while pop is low.
`timescale 1ns / 1ps
module thick_line_rasterizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  thr_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output thr_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import thr_pkg::*;

  logic [12:0] image_width, image_height;
  logic [2:0]  pixel_bytes;
  logic [5:0]  band_width;
  logic [7:0]  color_red, color_green, color_blue;
  cfg_t        cfg;

  logic        accept;
  logic        job_push, job_pop, job_empty;
  step_t       job_w, job_r;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      pixel_bytes  <= 3'd3;
      band_width   <= 6'd1;
      color_red    <= 8'd255;
      color_green  <= 8'd255;
      color_blue   <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[2:0];
        REG_BAND_WIDTH:   band_width   <= cfg_data[5:0];
        REG_COLOR_RED:    color_red    <= cfg_data[7:0];
        REG_COLOR_GREEN:  color_green  <= cfg_data[7:0];
        REG_COLOR_BLUE:   color_blue   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width       = (image_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : image_width;
    cfg.height      = (image_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : image_height;
    cfg.pixel_bytes = pixel_bytes;
    cfg.band        = (band_width > 6'(MAX_BAND)) ? 6'(MAX_BAND) : band_width;
    cfg.red         = color_red;
    cfg.green       = color_green;
    cfg.blue        = color_blue;
  end

  thr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (job_w)
  );

  thr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_w),
    .pop   (job_pop),
    .rdata (job_r),
    .full  (full),
    .empty (job_empty)
  );

  thr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job_in    (job_r),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### verif/thick_line_rasterizer_tb.sv
// Testbench for the thick line rasterizer: scoreboard class, stimulus, result checks.
`timescale 1ns / 1ps
module thick_line_rasterizer_tb;
  import thr_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 70;

  // Predicts the pixel writes of each command and checks the beats in order.
  class pixel_write_scoreboard;
    logic [12:0] img_w, img_h;
    logic [2:0]  pix_bytes;
    logic [5:0]  band;
    logic [7:0]  red, green, blue;
    logic signed [15:0] ln_x0, ln_y0, ln_x1, ln_y1, cur_major;
    logic steep, downward, drawing;
    out_item_t pending_writes[$];
    int errors;

    function new();
      img_w = 13'd640; img_h = 13'd480; pix_bytes = 3'd3; band = 6'd1;
      red = 8'hff; green = 8'hff; blue = 8'hff;
      ln_x0 = '0; ln_y0 = '0; ln_x1 = '0; ln_y1 = '0; cur_major = '0;
      steep = 1'b0; downward = 1'b0; drawing = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        REG_IMAGE_WIDTH: img_w = val;
        REG_IMAGE_HEIGHT: img_h = val;
        REG_PIXEL_BYTES: pix_bytes = val[2:0];
        REG_BAND_WIDTH: band = val[5:0];
        REG_COLOR_RED: red = val[7:0];
        REG_COLOR_GREEN: green = val[7:0];
        REG_COLOR_BLUE: blue = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void accept_command(in_item_t it);
      longint dx, dy, w, h, major_lim, minor_lim, s_maj, s_min, d_maj, d_min;
      longint pos, minor, first, m, row, col, addr;
      logic signed [15:0] s, e, end_major;
      int bw, pb;
      logic [1:0]  cnt;
      logic [23:0] data;
      out_item_t beat;
      out_item_t beats[$];
      if (it.cmd == CMD_LOAD) begin
        ln_x0 = it.start_x; ln_y0 = it.start_y;
        ln_x1 = it.end_x;   ln_y1 = it.end_y;
        dx = longint'(ln_x1) - longint'(ln_x0);
        dy = longint'(ln_y1) - longint'(ln_y0);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        steep = dy > dx;
        s = steep ? ln_y0 : ln_x0;
        e = steep ? ln_y1 : ln_x1;
        downward = e < s;
        cur_major = s;
        drawing = s != e;
        return;
      end
      if (!drawing) begin
        beat = '0;
        beat.last_of_step = 1'b1;
        beat.line_done = 1'b1;
        pending_writes.push_back(beat);
        return;
      end
      w = img_w; h = img_h;
      if (w > MAX_DIM) w = MAX_DIM;
      if (h > MAX_DIM) h = MAX_DIM;
      major_lim = steep ? h : w;
      minor_lim = steep ? w : h;
      s_maj = steep ? ln_y0 : ln_x0;
      s_min = steep ? ln_x0 : ln_y0;
      d_maj = longint'(steep ? ln_y1 : ln_x1) - s_maj;
      d_min = longint'(steep ? ln_x1 : ln_y1) - s_min;
      pos = cur_major;
      bw = band;
      if (bw > MAX_BAND) bw = MAX_BAND;
      pb = pix_bytes;
      if (pix_bytes == RGB_PIXEL_BYTES) begin
        cnt = 2'd3;
        data = {red, green, blue};
      end else begin
        cnt = 2'd1;
        data = {16'd0, red};
      end
      if (pos >= 0 && pos < major_lim && d_maj != 0) begin
        // signed division truncates toward zero
        minor = s_min + ((pos - s_maj) * d_min) / d_maj;
        first = minor - bw / 2;
        for (int k = 0; k < bw; k++) begin
          m = first + k;
          if (m < 0 || m >= minor_lim) continue;
          row = steep ? pos : m;
          col = steep ? m : pos;
          addr = (row * w + col) * pb;
          beat = '0;
          beat.byte_addr = addr[25:0];
          beat.byte_count = cnt;
          beat.pixel_data = data;
          beat.write_enable = 1'b1;
          beats.push_back(beat);
        end
      end
      if (beats.size() == 0) beats.push_back('0);
      cur_major = cur_major + (downward ? -16'sd1 : 16'sd1);
      end_major = steep ? ln_y1 : ln_x1;
      if (cur_major == end_major) drawing = 1'b0;
      foreach (beats[i]) beats[i].line_done = !drawing;
      beats[beats.size() - 1].last_of_step = 1'b1;
      foreach (beats[i]) pending_writes.push_back(beats[i]);
    endfunction

    function void field_check(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_write(out_item_t got);
      out_item_t exp_w;
      if (pending_writes.size() == 0) begin
        $error("unexpected result beat: addr %0d", got.byte_addr);
        errors++;
        return;
      end
      exp_w = pending_writes.pop_front();
      field_check("byte_addr", exp_w.byte_addr, got.byte_addr);
      field_check("byte_count", exp_w.byte_count, got.byte_count);
      field_check("pixel_data", exp_w.pixel_data, got.pixel_data);
      field_check("write_enable", exp_w.write_enable, got.write_enable);
      field_check("last_of_step", exp_w.last_of_step, got.last_of_step);
      field_check("line_done", exp_w.line_done, got.line_done);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [12:0] cfg_data = '0;

  pixel_write_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_pop_req = 1'b0;

  thick_line_rasterizer dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: check accepted beats, pick pop for the next edge
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_write(result);
      if (hold_pop_req) begin
        hold_left = HOLD_CYCLES;
        hold_pop_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst && ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_command(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.accept_command(it);
  endtask

  function automatic in_item_t load_cmd(int x0, int y0, int x1, int y1);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.start_x = 16'(x0); it.start_y = 16'(y0);
    it.end_x = 16'(x1);   it.end_y = 16'(y1);
    return it;
  endfunction

  // coordinate fields of a step are don't-care; fill them with noise
  function automatic in_item_t step_cmd();
    in_item_t it;
    it = load_cmd($urandom, $urandom, $urandom, $urandom);
    it.cmd = CMD_STEP;
    return it;
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 13'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, 13'(val));
  endtask

  // Block must be idle: drain, then allow trailing loads to retire
  task automatic set_config(int w, int h, int pb, int bw, int r, int g, int b);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PIXEL_BYTES, pb);
    write_reg(REG_BAND_WIDTH, bw);
    write_reg(REG_COLOR_RED, r);
    write_reg(REG_COLOR_GREEN, g);
    write_reg(REG_COLOR_BLUE, b);
    cfg_valid <= 1'b0;
  endtask

  function automatic int near_coord(int lim);
    int span;
    span = (lim > 200) ? 200 : lim;
    if (lim > 16 && $urandom_range(3) == 0) return lim - 8 + int'($urandom_range(16));
    return int'($urandom_range(span + 16)) - 8;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(7))
      0: return 1;
      1: return 4096;
      2: return 8191;
      default: return $urandom_range(2, 96);
    endcase
  endfunction

  function automatic int pick_band();
    case ($urandom_range(6))
      0: return 0;
      1: return 32;
      2: return 63;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic directed_part();
    push_command(step_cmd());                       // no line loaded yet
    push_command(load_cmd(5, 5, 5, 5));             // zero-length line
    push_command(step_cmd());
    push_command(load_cmd(0, 0, 4, 1));
    repeat (2) push_command(step_cmd());
    push_command(load_cmd(10, 10, 7, 2));           // steep, running backward
    repeat (2) push_command(step_cmd());
    push_command(load_cmd(-32768, -32768, 32767, 32767));
    push_command(step_cmd());
    push_command(load_cmd(32767, 100, -32768, -100));
    push_command(step_cmd());
    // oversized image and band, zero pixel size
    set_config(8191, 8191, 0, 63, 0, 0, 0);
    push_command(load_cmd(4095, 5, 4100, 7));
    repeat (2) push_command(step_cmd());
    // empty image, empty band
    set_config(0, 1, 7, 0, 255, 0, 255);
    push_command(load_cmd(0, 0, 3, 0));
    push_command(step_cmd());
    set_config(1, 1, 4, 2, 8'h5a, 8'ha5, 8'h3c);
    push_command(load_cmd(0, 0, 1, 0));
    repeat (2) push_command(step_cmd());           // second one runs past the end
    set_config(4096, 4096, 3, 32, 8'h12, 8'h34, 8'h56);
    push_command(load_cmd(0, -3, 0, 3));
    repeat (2) push_command(step_cmd());
  endtask

  task automatic random_phase(int n_items, bit hold_results);
    int sent, x0, y0, x1, y1, n_steps, reach;
    bit paused;
    sent = 0;
    paused = 1'b0;
    if (hold_results) hold_pop_req = 1'b1;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:74]: begin
          // a real line near the image, followed by steps along it
          reach = ($urandom_range(7) == 0) ? 60 : 12;
          x0 = near_coord(sb.img_w);
          y0 = near_coord(sb.img_h);
          x1 = x0 + int'($urandom_range(2 * reach)) - reach;
          y1 = y0 + int'($urandom_range(2 * reach)) - reach;
          push_command(load_cmd(x0, y0, x1, y1));
          n_steps = $urandom_range(1, 12);
          repeat (n_steps) push_command(step_cmd());
          sent += 1 + n_steps;
        end
        [75:87]: begin
          push_command(load_cmd($urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        default: begin
          push_command(step_cmd());
          sent++;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 25;
    rx_idle_pct = 72;
    directed_part();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 72;
        rx_idle_pct = 25;
      end else if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_config(pick_dim(), pick_dim(), $urandom_range(7), pick_band(),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255));
      random_phase(PHASE_ITEMS, ph == 0);
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
